// ===== rtl/slbt_pkg.sv =====
// ----------------------------------------------------------------------------
// slbt_pkg
// Types and constants shared by the sequence length batch tracker modules.
// ----------------------------------------------------------------------------
package slbt_pkg;

  localparam int unsigned OP_W        = 3;
  localparam int unsigned SEQ_W       = 8;
  localparam int unsigned TOK_W       = 20;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned CNT_W       = 17;
  localparam int unsigned LIVE_SEQ_W  = 9;
  localparam int unsigned LIVE_TOK_W  = 25;
  localparam int unsigned VOCAB_W     = 21;
  localparam int unsigned MAX_LEN_W   = 17;
  localparam int unsigned MAX_BATCH_W = 17;
  localparam int unsigned CFG_W       = 21;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TOKEN   = 3'd0,
    OP_START   = 3'd1,
    OP_COMMIT  = 3'd2,
    OP_DISCARD = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_BAD     = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_PHASE = 3'd1,
    ST_SIZE  = 3'd2,
    ST_RANGE = 3'd3,
    ST_POS   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_READY     = 2'd0,
    PH_PREPARED  = 2'd1,
    PH_EXECUTING = 2'd2
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOCAB     = 2'd0,
    CFG_MAX_LEN   = 2'd1,
    CFG_MAX_BATCH = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } back_state_e;

  typedef struct packed {
    logic [VOCAB_W-1:0]     vocab_size;
    logic [MAX_LEN_W-1:0]   max_model_length;
    logic [MAX_BATCH_W-1:0] max_batch_size;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [SEQ_W-1:0] sequence_index;
    logic [TOK_W-1:0] token_id;
    logic [POS_W-1:0] position;
    logic             wants_logits;
    logic             first_of_batch;
    logic             last_of_batch;
  } item_t;

  typedef struct packed {
    status_e               status;
    logic [CNT_W-1:0]      batch_tokens;
    logic [CNT_W-1:0]      logits_count;
    logic [CNT_W-1:0]      peak_context;
    phase_e                phase_now;
    logic [LIVE_SEQ_W-1:0] active_seqs;
    logic [LIVE_TOK_W-1:0] total_tokens;
  } result_t;

endpackage

// ===== rtl/slbt_front.sv =====
// ----------------------------------------------------------------------------
// slbt_front
// Accepts items, classifies the operation code and holds them in a
// two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module slbt_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [slbt_pkg::OP_W-1:0]    operation_i,
  input  logic [slbt_pkg::SEQ_W-1:0]   sequence_index_i,
  input  logic [slbt_pkg::TOK_W-1:0]   token_id_i,
  input  logic [slbt_pkg::POS_W-1:0]   position_i,
  input  logic                         wants_logits_i,
  input  logic                         first_of_batch_i,
  input  logic                         last_of_batch_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output slbt_pkg::item_t              item_o
);

  slbt_pkg::item_t entry_q [2];
  slbt_pkg::item_t in_item;
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            do_push, do_pop;

  always_comb begin
    in_item = '{
      op:             slbt_pkg::OP_BAD,
      sequence_index: sequence_index_i,
      token_id:       token_id_i,
      position:       position_i,
      wants_logits:   wants_logits_i,
      first_of_batch: first_of_batch_i,
      last_of_batch:  last_of_batch_i
    };
    case (operation_i)
      slbt_pkg::OP_TOKEN:   in_item.op = slbt_pkg::OP_TOKEN;
      slbt_pkg::OP_START:   in_item.op = slbt_pkg::OP_START;
      slbt_pkg::OP_COMMIT:  in_item.op = slbt_pkg::OP_COMMIT;
      slbt_pkg::OP_DISCARD: in_item.op = slbt_pkg::OP_DISCARD;
      slbt_pkg::OP_CLEAR:   in_item.op = slbt_pkg::OP_CLEAR;
      default:              in_item.op = slbt_pkg::OP_BAD;
    endcase
  end

  assign full_o   = (count_q == 2'd2);
  assign empty_o  = (count_q == 2'd0);
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && !empty_o;
  assign item_o   = entry_q[rd_ptr_q];
  assign wr_ptr_d = wr_ptr_q ^ do_push;
  assign rd_ptr_d = rd_ptr_q ^ do_pop;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

// ===== rtl/slbt_back.sv =====
// ----------------------------------------------------------------------------
// slbt_back
// Executes queued items against the length table and holds the result.
// ----------------------------------------------------------------------------
module slbt_back #(
  parameter int unsigned NUM_SEQUENCES = 64,
  parameter int unsigned LENGTH_BITS   = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slbt_pkg::cfg_t    cfg_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  input  slbt_pkg::item_t   item_i,
  output logic              empty_o,
  input  logic              pop_i,
  output slbt_pkg::result_t result_o
);

  localparam int unsigned IDX_W = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
  localparam int unsigned DEPTH = 2 ** IDX_W;
  localparam int unsigned LW    = slbt_pkg::LIVE_TOK_W;
  localparam int unsigned SW    = slbt_pkg::LIVE_SEQ_W;
  localparam int unsigned CW    = slbt_pkg::CNT_W;
  localparam logic [slbt_pkg::SEQ_W:0] SEQ_LIM = (slbt_pkg::SEQ_W + 1)'(NUM_SEQUENCES);

  // Each entry has two banks; sel says which one holds the committed length,
  // touch marks entries whose pending length lives in the other bank.
  logic [LENGTH_BITS-1:0] mem [2*DEPTH];

  slbt_pkg::back_state_e state_q, state_d;
  slbt_pkg::item_t       item_q;
  logic [LENGTH_BITS-1:0] rd_q;
  logic                   rd_ok_q;
  logic [DEPTH-1:0]       sel_q, sel_d, cval_q, cval_d, touch_q, touch_d;
  slbt_pkg::phase_e       phase_q, phase_d;
  logic                   gath_q, gath_d;
  logic [CW-1:0]          tcnt_q, tcnt_d, lcnt_q, lcnt_d, peak_q, peak_d;
  logic [SW-1:0]          cseq_q, cseq_d, pseq_q, pseq_d;
  logic [LW-1:0]          ctok_q, ctok_d, ptok_q, ptok_d;
  slbt_pkg::result_t      res_q, res_d;
  logic                   out_vld_q, out_vld_d;

  logic                   take;
  logic [IDX_W-1:0]       head_idx, idx;
  logic                   head_pend;
  logic                   rd_bank;
  logic [LENGTH_BITS-1:0] len, len_inc;
  logic                   in_rng;
  logic                   wr_en;
  logic [IDX_W:0]         wr_addr;

  assign head_idx  = item_i.sequence_index[IDX_W-1:0];
  assign head_pend = (item_i.op == slbt_pkg::OP_TOKEN) && !item_i.first_of_batch
                     && touch_q[head_idx];
  assign rd_bank   = sel_q[head_idx] ^ head_pend;
  assign take      = (state_q == slbt_pkg::BK_IDLE) && !q_empty_i && (!out_vld_q || pop_i);
  assign q_pop_o   = take;

  assign idx     = item_q.sequence_index[IDX_W-1:0];
  assign in_rng  = {1'b0, item_q.sequence_index} < SEQ_LIM;
  assign len     = rd_ok_q ? rd_q : '0;
  assign len_inc = len + 1'b1;
  assign wr_addr = {~sel_q[idx], idx};

  always_comb begin
    state_d   = state_q;
    sel_d     = sel_q;
    cval_d    = cval_q;
    touch_d   = touch_q;
    phase_d   = phase_q;
    gath_d    = gath_q;
    tcnt_d    = tcnt_q;
    lcnt_d    = lcnt_q;
    peak_d    = peak_q;
    cseq_d    = cseq_q;
    ctok_d    = ctok_q;
    pseq_d    = pseq_q;
    ptok_d    = ptok_q;
    out_vld_d = out_vld_q && !pop_i;
    res_d     = res_q;
    wr_en     = 1'b0;
    case (state_q)
      slbt_pkg::BK_IDLE: begin
        if (take) begin
          state_d = slbt_pkg::BK_EXEC;
        end
      end
      slbt_pkg::BK_EXEC: begin
        state_d      = slbt_pkg::BK_IDLE;
        res_d.status = slbt_pkg::ST_OK;
        case (item_q.op)
          slbt_pkg::OP_TOKEN: begin
            if (item_q.first_of_batch && phase_q != slbt_pkg::PH_READY) begin
              res_d.status = slbt_pkg::ST_PHASE;
            end else if (!item_q.first_of_batch && !gath_q) begin
              res_d.status = slbt_pkg::ST_PHASE;
            end else begin
              if (item_q.first_of_batch) begin
                // Opening a batch makes every pending length equal its committed one.
                touch_d = '0;
                tcnt_d  = '0;
                lcnt_d  = '0;
                peak_d  = '0;
                pseq_d  = cseq_q;
                ptok_d  = ctok_q;
                gath_d  = 1'b1;
              end
              if (tcnt_d >= cfg_i.max_batch_size) begin
                res_d.status = slbt_pkg::ST_SIZE;
              end else if (!in_rng
                           || {1'b0, item_q.token_id} >= cfg_i.vocab_size
                           || {1'b0, item_q.position} >= cfg_i.max_model_length) begin
                res_d.status = slbt_pkg::ST_RANGE;
              end else if (33'(item_q.position) != 33'(len)) begin
                res_d.status = slbt_pkg::ST_POS;
              end else if (&len) begin
                res_d.status = slbt_pkg::ST_RANGE;
              end
              if (res_d.status != slbt_pkg::ST_OK) begin
                gath_d = 1'b0;
                tcnt_d = '0;
                lcnt_d = '0;
                peak_d = '0;
              end else begin
                wr_en        = 1'b1;
                touch_d[idx] = 1'b1;
                tcnt_d       = tcnt_d + 1'b1;
                lcnt_d       = lcnt_d + CW'(item_q.wants_logits);
                if (33'(len_inc) > 33'(peak_d)) begin
                  peak_d = CW'(len_inc);
                end
                ptok_d = ptok_d + 1'b1;
                pseq_d = pseq_d + SW'(len == '0);
                if (item_q.last_of_batch) begin
                  gath_d  = 1'b0;
                  phase_d = slbt_pkg::PH_PREPARED;
                end
              end
            end
          end
          slbt_pkg::OP_START: begin
            if (gath_q || phase_q != slbt_pkg::PH_PREPARED) begin
              res_d.status = slbt_pkg::ST_PHASE;
            end else begin
              phase_d = slbt_pkg::PH_EXECUTING;
            end
          end
          slbt_pkg::OP_COMMIT: begin
            if (gath_q || phase_q != slbt_pkg::PH_EXECUTING) begin
              res_d.status = slbt_pkg::ST_PHASE;
            end else begin
              sel_d   = sel_q ^ touch_q;
              cval_d  = cval_q | touch_q;
              touch_d = '0;
              cseq_d  = pseq_q;
              ctok_d  = ptok_q;
              phase_d = slbt_pkg::PH_READY;
            end
          end
          slbt_pkg::OP_DISCARD: begin
            if (gath_q || phase_q != slbt_pkg::PH_PREPARED) begin
              res_d.status = slbt_pkg::ST_PHASE;
            end else begin
              phase_d = slbt_pkg::PH_READY;
            end
          end
          slbt_pkg::OP_CLEAR: begin
            if (gath_q || phase_q != slbt_pkg::PH_READY) begin
              res_d.status = slbt_pkg::ST_PHASE;
            end else if (!in_rng) begin
              res_d.status = slbt_pkg::ST_RANGE;
            end else begin
              cval_d[idx] = 1'b0;
              cseq_d      = cseq_q - SW'(len != '0);
              ctok_d      = ctok_q - LW'(len);
            end
          end
          default: begin
            res_d.status = slbt_pkg::ST_PHASE;
          end
        endcase
        res_d.batch_tokens = tcnt_d;
        res_d.logits_count = lcnt_d;
        res_d.peak_context = peak_d;
        res_d.phase_now    = phase_d;
        res_d.active_seqs  = cseq_d;
        res_d.total_tokens = ctok_d;
        out_vld_d          = 1'b1;
      end
      default: begin
        state_d = slbt_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= slbt_pkg::BK_IDLE;
      sel_q     <= '0;
      cval_q    <= '0;
      touch_q   <= '0;
      phase_q   <= slbt_pkg::PH_READY;
      gath_q    <= 1'b0;
      tcnt_q    <= '0;
      lcnt_q    <= '0;
      peak_q    <= '0;
      cseq_q    <= '0;
      ctok_q    <= '0;
      pseq_q    <= '0;
      ptok_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sel_q     <= sel_d;
      cval_q    <= cval_d;
      touch_q   <= touch_d;
      phase_q   <= phase_d;
      gath_q    <= gath_d;
      tcnt_q    <= tcnt_d;
      lcnt_q    <= lcnt_d;
      peak_q    <= peak_d;
      cseq_q    <= cseq_d;
      ctok_q    <= ctok_d;
      pseq_q    <= pseq_d;
      ptok_q    <= ptok_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (take) begin
      item_q  <= item_i;
      rd_q    <= mem[{rd_bank, head_idx}];
      rd_ok_q <= head_pend || cval_q[head_idx];
    end
    if (wr_en) begin
      mem[wr_addr] <= len_inc;
    end
  end

  assign empty_o  = !out_vld_q;
  assign result_o = res_q;

endmodule

// ===== rtl/sequence_length_batch_tracker.sv =====
// ----------------------------------------------------------------------------
// sequence_length_batch_tracker
// Tracks committed and pending sequence lengths across batch preparation.
// ----------------------------------------------------------------------------
// Each item passes through the execution stage in order: a read of the length
// table through its single port, then a check, update and registering of the
// result. A new item is taken only after the previous one has finished and
// while the result register is empty or being read. A two-entry queue sits
// in front of the execution stage and one result register behind it. Commit
// and batch opening act on all sequences at once through per-sequence flags,
// and no clearing pass is run after reset.
module sequence_length_batch_tracker #(
  parameter int unsigned NUM_SEQUENCES = 64,
  parameter int unsigned LENGTH_BITS   = 17
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [slbt_pkg::OP_W-1:0]         operation_i,
  input  logic [slbt_pkg::SEQ_W-1:0]        sequence_index_i,
  input  logic [slbt_pkg::TOK_W-1:0]        token_id_i,
  input  logic [slbt_pkg::POS_W-1:0]        position_i,
  input  logic                              wants_logits_i,
  input  logic                              first_of_batch_i,
  input  logic                              last_of_batch_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [2:0]                        status_o,
  output logic [slbt_pkg::CNT_W-1:0]        batch_tokens_o,
  output logic [slbt_pkg::CNT_W-1:0]        logits_count_o,
  output logic [slbt_pkg::CNT_W-1:0]        peak_context_o,
  output logic [1:0]                        phase_now_o,
  output logic [slbt_pkg::LIVE_SEQ_W-1:0]   active_seqs_o,
  output logic [slbt_pkg::LIVE_TOK_W-1:0]   total_tokens_o,
  input  logic                              cfg_we_i,
  input  logic [slbt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [slbt_pkg::CFG_W-1:0]        cfg_data_i
);

  slbt_pkg::cfg_t    cfg_q, cfg_d;
  slbt_pkg::item_t   head;
  slbt_pkg::result_t res;
  logic              q_empty, q_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (slbt_pkg::cfg_reg_e'(cfg_idx_i))
        slbt_pkg::CFG_VOCAB:     cfg_d.vocab_size       = cfg_data_i;
        slbt_pkg::CFG_MAX_LEN:   cfg_d.max_model_length = cfg_data_i[slbt_pkg::MAX_LEN_W-1:0];
        slbt_pkg::CFG_MAX_BATCH: cfg_d.max_batch_size   = cfg_data_i[slbt_pkg::MAX_BATCH_W-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{vocab_size:       21'd32768,
                 max_model_length: 17'd4096,
                 max_batch_size:   17'd512};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  slbt_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .operation_i      (operation_i),
    .sequence_index_i (sequence_index_i),
    .token_id_i       (token_id_i),
    .position_i       (position_i),
    .wants_logits_i   (wants_logits_i),
    .first_of_batch_i (first_of_batch_i),
    .last_of_batch_i  (last_of_batch_i),
    .empty_o          (q_empty),
    .pop_i            (q_pop),
    .item_o           (head)
  );

  slbt_back #(
    .NUM_SEQUENCES (NUM_SEQUENCES),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .item_i    (head),
    .empty_o   (empty),
    .pop_i     (pop),
    .result_o  (res)
  );

  assign status_o       = res.status;
  assign batch_tokens_o = res.batch_tokens;
  assign logits_count_o = res.logits_count;
  assign peak_context_o = res.peak_context;
  assign phase_now_o    = res.phase_now;
  assign active_seqs_o  = res.active_seqs;
  assign total_tokens_o = res.total_tokens;

`ifndef SYNTHESIS
  a_phase_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> phase_now_o <= slbt_pkg::PH_EXECUTING)
    else $error("result carries an undefined phase");

  // Only a token can answer too large or not contiguous, and it drops the batch.
  a_error_drops_batch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o == slbt_pkg::ST_SIZE || status_o == slbt_pkg::ST_POS))
    |-> (batch_tokens_o == '0 && logits_count_o == '0 && peak_context_o == '0))
    else $error("token error left batch counters standing");

  a_live_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> {1'b0, active_seqs_o} <= (slbt_pkg::LIVE_SEQ_W + 1)'(NUM_SEQUENCES))
    else $error("live sequence count exceeds table size");
`endif

endmodule
